// ===== hw/rtl/tcgr_pkg.sv =====
`default_nettype none

package tcgr_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int ROW_IDX_W  = 5;

    localparam logic [2:0] REG_COLUMN_COUNT = 3'd0;
    localparam logic [2:0] REG_ROW_COUNT    = 3'd1;
    localparam logic [2:0] REG_CHAR_WIDTH   = 3'd2;
    localparam logic [2:0] REG_CHAR_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_FIRST_CODE   = 3'd4;
    localparam logic [2:0] REG_CODE_COUNT   = 3'd5;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_ROW    = 2'd1;
    localparam logic [1:0] OP_SCROLL = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_RETURN   = 8'h0D;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;

    localparam logic [15:0] WIDTH_MASK_BASE = 16'hFF00;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic [4:0] glyph_row;
        logic [7:0] row_bits;
    } t_request;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  lit_mask;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [8:0] column_count;
        logic [7:0] row_count;
        logic [3:0] char_width;
        logic [5:0] char_height;
        logic [7:0] first_code;
        logic [8:0] code_count;
    } t_config;

endpackage

`default_nettype wire

// ===== hw/rtl/tcgr_ram.sv =====
`default_nettype none

module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/tcgr_cfg.sv =====
`default_nettype none

module tcgr_cfg #(
    parameter int MAX_COLUMNS     = 256,
    parameter int MAX_ROWS        = 128,
    parameter int MAX_CELL_HEIGHT = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tcgr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tcgr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [tcgr_pkg::APB_DATA_W-1:0]  prdata,
    output tcgr_pkg::t_config                     o_cfg
);

    tcgr_pkg::t_config r_cfg;
    tcgr_pkg::t_config n_cfg;
    logic              wr_en;
    logic [2:0]        reg_idx;
    logic [8:0]        v_col;
    logic [7:0]        v_row;
    logic [3:0]        v_width;
    logic [5:0]        v_height;
    logic [8:0]        v_count;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb begin
        v_col = pwdata[8:0];
        if (v_col == 9'd0) begin
            v_col = 9'd1;
        end else if (int'(v_col) > MAX_COLUMNS) begin
            v_col = 9'(MAX_COLUMNS);
        end

        v_row = pwdata[7:0];
        if (v_row == 8'd0) begin
            v_row = 8'd1;
        end else if (int'(v_row) > MAX_ROWS) begin
            v_row = 8'(MAX_ROWS);
        end

        v_width = pwdata[3:0];
        if (v_width == 4'd0) begin
            v_width = 4'd1;
        end else if (v_width > 4'd8) begin
            v_width = 4'd8;
        end

        v_height = pwdata[5:0];
        if (v_height == 6'd0) begin
            v_height = 6'd1;
        end else if (int'(v_height) > MAX_CELL_HEIGHT) begin
            v_height = 6'(MAX_CELL_HEIGHT);
        end

        v_count = pwdata[8:0];
        if (v_count > 9'd256) begin
            v_count = 9'd256;
        end

        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                tcgr_pkg::REG_COLUMN_COUNT: n_cfg.column_count = v_col;
                tcgr_pkg::REG_ROW_COUNT:    n_cfg.row_count    = v_row;
                tcgr_pkg::REG_CHAR_WIDTH:   n_cfg.char_width   = v_width;
                tcgr_pkg::REG_CHAR_HEIGHT:  n_cfg.char_height  = v_height;
                tcgr_pkg::REG_FIRST_CODE:   n_cfg.first_code   = pwdata[7:0];
                tcgr_pkg::REG_CODE_COUNT:   n_cfg.code_count   = v_count;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.column_count <= 9'd80;
            r_cfg.row_count    <= 8'd30;
            r_cfg.char_width   <= 4'd8;
            r_cfg.char_height  <= 6'd16;
            r_cfg.first_code   <= 8'd0;
            r_cfg.code_count   <= 9'd256;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (reg_idx)
            tcgr_pkg::REG_COLUMN_COUNT: prdata = {23'd0, r_cfg.column_count};
            tcgr_pkg::REG_ROW_COUNT:    prdata = {24'd0, r_cfg.row_count};
            tcgr_pkg::REG_CHAR_WIDTH:   prdata = {28'd0, r_cfg.char_width};
            tcgr_pkg::REG_CHAR_HEIGHT:  prdata = {26'd0, r_cfg.char_height};
            tcgr_pkg::REG_FIRST_CODE:   prdata = {24'd0, r_cfg.first_code};
            tcgr_pkg::REG_CODE_COUNT:   prdata = {23'd0, r_cfg.code_count};
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/tcgr_seq.sv =====
`default_nettype none

module tcgr_seq #(
    parameter int MAX_CELL_HEIGHT = 32,
    parameter int GLYPH_CODES     = 256,
    localparam int DEPTH  = GLYPH_CODES * MAX_CELL_HEIGHT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tcgr_pkg::t_config i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire tcgr_pkg::t_request i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output tcgr_pkg::t_result      o_out_data,
    output logic                   o_ram_we,
    output logic [ADDR_W-1:0]      o_ram_waddr,
    output logic [7:0]             o_ram_wdata,
    output logic [ADDR_W-1:0]      o_ram_raddr,
    input  wire logic [7:0]        i_ram_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_QUIET  = 3'd1;
    localparam logic [2:0] S_PREP   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_ROW    = 3'd4;

    logic [2:0]                         r_state, n_state;
    logic [8:0]                         r_col, n_col;
    logic [6:0]                         r_row, n_row;
    logic [7:0]                         r_code, n_code;
    logic                               r_zero, n_zero;
    logic                               r_scroll_pend, n_scroll_pend;
    logic                               r_draw, n_draw;
    logic [10:0]                        r_x0, n_x0;
    logic [11:0]                        r_y0, n_y0;
    logic [tcgr_pkg::ROW_IDX_W-1:0]     r_rowidx, n_rowidx;
    logic [7:0]                         r_mask, n_mask;
    logic                               r_out_valid, n_out_valid;
    tcgr_pkg::t_result                  r_out, n_out;

    logic        accept;
    logic        slot_free;
    logic        row_fits;
    logic        in_range;
    logic        row_last;
    logic [7:0]  shown;
    logic [9:0]  range_end;
    logic [12:0] prod_x;
    logic [12:0] prod_y;
    logic [15:0] width_shift;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign row_fits   = (8'({1'b0, r_row}) + 8'd1) < i_cfg.row_count;
    assign range_end  = {2'b00, i_cfg.first_code} + {1'b0, i_cfg.code_count};
    assign in_range   = (i_in_data.char_code >= i_cfg.first_code)
                        && ({2'b00, i_in_data.char_code} < range_end);
    assign shown      = in_range ? i_in_data.char_code : tcgr_pkg::CHAR_QUESTION;
    assign row_last   = ({1'b0, r_rowidx} == (i_cfg.char_height - 6'd1));
    assign prod_x     = r_col * i_cfg.char_width;
    assign prod_y     = r_row * i_cfg.char_height;
    assign width_shift = tcgr_pkg::WIDTH_MASK_BASE >> i_cfg.char_width;

    assign o_ram_we    = accept && (i_in_data.command == tcgr_pkg::CMD_LOAD)
                         && (int'(i_in_data.char_code) < GLYPH_CODES)
                         && (int'(i_in_data.glyph_row) < MAX_CELL_HEIGHT);
    assign o_ram_waddr = ADDR_W'(int'(i_in_data.char_code) * MAX_CELL_HEIGHT
                                 + int'(i_in_data.glyph_row));
    assign o_ram_wdata = i_in_data.row_bits;
    assign o_ram_raddr = ADDR_W'(int'(r_code) * MAX_CELL_HEIGHT + int'(n_rowidx));

    always_comb begin
        n_state       = r_state;
        n_col         = r_col;
        n_row         = r_row;
        n_code        = r_code;
        n_zero        = r_zero;
        n_scroll_pend = r_scroll_pend;
        n_draw        = r_draw;
        n_x0          = r_x0;
        n_y0          = r_y0;
        n_rowidx      = r_rowidx;
        n_mask        = r_mask;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.command == tcgr_pkg::CMD_LOAD) begin
                        n_state = S_QUIET;
                    end else if (i_in_data.char_code == tcgr_pkg::CHAR_NEWLINE) begin
                        n_col  = '0;
                        n_draw = 1'b0;
                        if (row_fits) begin
                            n_row   = r_row + 7'd1;
                            n_state = S_QUIET;
                        end else begin
                            n_state = S_SCROLL;
                        end
                    end else if (i_in_data.char_code == tcgr_pkg::CHAR_RETURN) begin
                        n_col   = '0;
                        n_state = S_QUIET;
                    end else begin
                        n_scroll_pend = 1'b0;
                        if (r_col >= i_cfg.column_count) begin
                            n_col = '0;
                            if (row_fits) begin
                                n_row = r_row + 7'd1;
                            end else begin
                                n_scroll_pend = 1'b1;
                            end
                        end
                        n_code  = shown;
                        n_zero  = (int'(shown) >= GLYPH_CODES);
                        n_draw  = 1'b1;
                        n_state = S_PREP;
                    end
                end
            end
            S_QUIET: begin
                if (slot_free) begin
                    n_out       = '0;
                    n_out.op    = tcgr_pkg::OP_NONE;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_PREP: begin
                n_x0     = prod_x[10:0];
                n_y0     = prod_y[11:0];
                n_mask   = width_shift[7:0];
                n_col    = r_col + 9'd1;
                n_rowidx = '0;
                n_state  = r_scroll_pend ? S_SCROLL : S_ROW;
            end
            S_SCROLL: begin
                if (slot_free) begin
                    n_out       = '0;
                    n_out.op    = tcgr_pkg::OP_SCROLL;
                    n_out.last  = !r_draw;
                    n_out_valid = 1'b1;
                    n_state     = r_draw ? S_ROW : S_IDLE;
                end
            end
            S_ROW: begin
                if (slot_free) begin
                    n_out.op       = tcgr_pkg::OP_ROW;
                    n_out.pixel_x  = r_x0;
                    n_out.pixel_y  = r_y0 + 12'(r_rowidx);
                    n_out.lit_mask = r_zero ? 8'd0 : (i_ram_rdata & r_mask);
                    n_out.last     = row_last;
                    n_out_valid    = 1'b1;
                    n_rowidx       = r_rowidx + 1'b1;
                    if (row_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_col         <= '0;
            r_row         <= '0;
            r_scroll_pend <= 1'b0;
            r_draw        <= 1'b0;
            r_rowidx      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_col         <= n_col;
            r_row         <= n_row;
            r_scroll_pend <= n_scroll_pend;
            r_draw        <= n_draw;
            r_rowidx      <= n_rowidx;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_zero <= n_zero;
        r_x0   <= n_x0;
        r_y0   <= n_y0;
        r_mask <= n_mask;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_glyph_renderer.sv =====
// Text console renderer: glyph rows are loaded into an internal font memory one
// request at a time, and character requests move the cursor and produce drawing
// results (glyph row writes and scroll commands) for a downstream pixel writer.
// Loads, carriage returns and non-scrolling newlines give one empty result; a
// printable character gives a scroll result first when it wraps into a scroll,
// then one result per glyph row, as the single font memory read port delivers
// one glyph row per cycle while the result port is not stalled. A new request
// is taken as soon as the last result of the previous one sits in the output
// register. Configuration must be written only while idle (not enforced here).
`default_nettype none

module text_console_glyph_renderer #(
    parameter int MAX_COLUMNS     = 256,
    parameter int MAX_ROWS        = 128,
    parameter int MAX_CELL_HEIGHT = 32,
    parameter int GLYPH_CODES     = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tcgr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tcgr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [tcgr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire tcgr_pkg::t_request              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output tcgr_pkg::t_result                    o_out_data
);

    localparam int DEPTH  = GLYPH_CODES * MAX_CELL_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tcgr_pkg::t_config cfg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    assign pready = 1'b1;

    tcgr_cfg #(
        .MAX_COLUMNS     (MAX_COLUMNS),
        .MAX_ROWS        (MAX_ROWS),
        .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    tcgr_seq #(
        .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT),
        .GLYPH_CODES     (GLYPH_CODES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    tcgr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    a_write_on_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (i_in_valid && o_in_ready)
    ) else $error("font memory written outside an accepted request");

    a_busy_mid_request: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> !o_in_ready
    ) else $error("request accepted before the previous one finished");

    a_quiet_fields_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.op != tcgr_pkg::OP_ROW))
            |-> (o_out_data.pixel_x == '0 && o_out_data.pixel_y == '0
                 && o_out_data.lit_mask == '0)
    ) else $error("non-drawing result carries pixel data");

    a_accept_then_no_ready: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready
    ) else $error("ready stayed high right after an accepted request");

endmodule

`default_nettype wire

// ===== tb/tb_text_console_glyph_renderer.sv =====
module tb_text_console_glyph_renderer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_SPARE_LOW  = 3'd6;
    localparam logic [2:0] REG_SPARE_HIGH = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 40;

    logic                                i_clk   = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                psel    = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite  = 1'b0;
    logic [tcgr_pkg::APB_ADDR_W-1:0]     paddr   = '0;
    logic [tcgr_pkg::APB_DATA_W-1:0]     pwdata  = '0;
    logic [tcgr_pkg::APB_DATA_W-1:0]     prdata;
    logic                                pready;
    logic                                i_in_valid  = 1'b0;
    logic                                o_in_ready;
    tcgr_pkg::t_request                  i_in_data   = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    tcgr_pkg::t_result                   o_out_data;

    tcgr_pkg::t_request text_stream[$];
    tcgr_pkg::t_result  expected_draws[$];
    tcgr_pkg::t_result  draw_batch[$];
    tcgr_pkg::t_config  layout = '{9'd80, 8'd30, 4'd8, 6'd16, 8'd0, 9'd256};
    logic [7:0] font_rows [0:8191];
    logic [8:0] cursor_col  = '0;
    logic [6:0] cursor_line = '0;
    bit         glyph_loaded [0:8191];

    int queued_requests   = 0;
    int accepted_requests = 0;
    int errors            = 0;
    int quiet_cycles      = 0;
    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    int hold_left         = 0;
    bit hold_armed        = 1'b0;
    bit held_once         = 1'b0;

    text_console_glyph_renderer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic covers(logic [7:0] code);
        return int'(code) >= int'(layout.first_code) &&
               int'(code) < int'(layout.first_code) + int'(layout.code_count);
    endfunction

    function automatic void add_draw(logic [1:0] op, int x, int y, logic [7:0] mask);
        tcgr_pkg::t_result r;
        r.op       = op;
        r.pixel_x  = 11'(x);
        r.pixel_y  = 12'(y);
        r.lit_mask = mask;
        r.last     = 1'b0;
        draw_batch.push_back(r);
    endfunction

    function automatic void advance_line();
        cursor_col = '0;
        if (int'(cursor_line) + 1 < int'(layout.row_count)) begin
            cursor_line = cursor_line + 7'd1;
        end else begin
            add_draw(tcgr_pkg::OP_SCROLL, 0, 0, 8'h00);
        end
    endfunction

    function automatic void render_request(tcgr_pkg::t_request rq);
        logic [7:0]        shown;
        logic [7:0]        width_mask;
        int                x0;
        int                y0;
        tcgr_pkg::t_result tail;
        draw_batch.delete();
        if (rq.command == tcgr_pkg::CMD_LOAD) begin
            font_rows[{rq.char_code, rq.glyph_row}] = rq.row_bits;
        end else if (rq.char_code == tcgr_pkg::CHAR_NEWLINE) begin
            advance_line();
        end else if (rq.char_code == tcgr_pkg::CHAR_RETURN) begin
            cursor_col = '0;
        end else begin
            if (cursor_col >= layout.column_count) begin
                advance_line();
            end
            shown      = covers(rq.char_code) ? rq.char_code : tcgr_pkg::CHAR_QUESTION;
            width_mask = 8'(tcgr_pkg::WIDTH_MASK_BASE >> layout.char_width);
            x0         = int'(cursor_col) * int'(layout.char_width);
            y0         = int'(cursor_line) * int'(layout.char_height);
            for (int r = 0; r < int'(layout.char_height); r++) begin
                add_draw(tcgr_pkg::OP_ROW, x0, y0 + r,
                         font_rows[{shown, 5'(r)}] & width_mask);
            end
            cursor_col = cursor_col + 9'd1;
        end
        if (draw_batch.size() == 0) begin
            add_draw(tcgr_pkg::OP_NONE, 0, 0, 8'h00);
        end
        tail      = draw_batch.pop_back();
        tail.last = 1'b1;
        draw_batch.push_back(tail);
        foreach (draw_batch[i]) begin
            expected_draws.push_back(draw_batch[i]);
        end
    endfunction

    function automatic void push_request(logic cmd, logic [7:0] code, logic [4:0] row,
                                         logic [7:0] bits);
        tcgr_pkg::t_request rq;
        rq.command   = cmd;
        rq.char_code = code;
        rq.glyph_row = row;
        rq.row_bits  = bits;
        if (cmd == tcgr_pkg::CMD_LOAD) begin
            glyph_loaded[{code, row}] = 1'b1;
        end
        text_stream.push_back(rq);
        queued_requests++;
    endfunction

    // A drawn glyph must have every row it shows loaded first.
    function automatic void queue_char(logic [7:0] code);
        logic [7:0] shown;
        shown = covers(code) ? code : tcgr_pkg::CHAR_QUESTION;
        if (code != tcgr_pkg::CHAR_NEWLINE && code != tcgr_pkg::CHAR_RETURN) begin
            for (int r = 0; r < int'(layout.char_height); r++) begin
                if (!glyph_loaded[{shown, 5'(r)}]) begin
                    push_request(tcgr_pkg::CMD_LOAD, shown, 5'(r), 8'($urandom));
                end
            end
        end
        push_request(tcgr_pkg::CMD_PUT, code, 5'($urandom_range(31)), 8'($urandom));
    endfunction

    function automatic logic [7:0] pick_char();
        unique case ($urandom_range(5))
            0: return (layout.char_height <= 6'd8) ? 8'($urandom_range(255)) : 8'h41;
            1: return layout.first_code;
            2: return layout.first_code - 8'd1;
            3: return 8'(int'(layout.first_code) + int'(layout.code_count) - 1);
            4: return 8'(int'(layout.first_code) + int'(layout.code_count));
            default: return 8'h41 + 8'($urandom_range(3));
        endcase
    endfunction

    function automatic void queue_random_text(int budget);
        int start;
        int pick;
        start = queued_requests;
        while (queued_requests - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                queue_char(tcgr_pkg::CHAR_NEWLINE);
            end else if (pick < 15) begin
                queue_char(tcgr_pkg::CHAR_RETURN);
            end else if (pick < 30) begin
                push_request(tcgr_pkg::CMD_LOAD, 8'($urandom), 5'($urandom), 8'($urandom));
            end else begin
                queue_char(pick_char());
            end
        end
    endfunction

    task automatic write_register(logic [2:0] index, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        unique case (index)
            tcgr_pkg::REG_COLUMN_COUNT:
                layout.column_count = 9'(clamp(int'(value & 32'h1FF), 1, 256));
            tcgr_pkg::REG_ROW_COUNT:
                layout.row_count    = 8'(clamp(int'(value & 32'hFF), 1, 128));
            tcgr_pkg::REG_CHAR_WIDTH:
                layout.char_width   = 4'(clamp(int'(value & 32'hF), 1, 8));
            tcgr_pkg::REG_CHAR_HEIGHT:
                layout.char_height  = 6'(clamp(int'(value & 32'h3F), 1, 32));
            tcgr_pkg::REG_FIRST_CODE:
                layout.first_code   = value[7:0];
            tcgr_pkg::REG_CODE_COUNT:
                layout.code_count   = 9'(clamp(int'(value & 32'h1FF), 0, 256));
            default: ;
        endcase
    endtask

    task automatic set_layout(int cols, int rows, int width, int height, int first, int count);
        write_register(tcgr_pkg::REG_COLUMN_COUNT, cols);
        write_register(tcgr_pkg::REG_ROW_COUNT, rows);
        write_register(tcgr_pkg::REG_CHAR_WIDTH, width);
        write_register(tcgr_pkg::REG_CHAR_HEIGHT, height);
        write_register(tcgr_pkg::REG_FIRST_CODE, first);
        write_register(tcgr_pkg::REG_CODE_COUNT, count);
    endtask

    task automatic wait_idle();
        while (accepted_requests != queued_requests || expected_draws.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            offer = text_stream.size() != 0 && $urandom_range(99) >= send_idle_pct;
            if (offer) begin
                i_in_data <= text_stream.pop_front();
            end
            i_in_valid <= offer;
        end
    end

    always @(posedge i_clk) begin
        logic take;
        if (!i_rst_n) begin
            take = 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            take = 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !held_once && o_out_valid) begin
            take = 1'b0;
            hold_left <= HOLD_CYCLES;
            held_once <= 1'b1;
        end else begin
            take = $urandom_range(99) >= recv_stall_pct;
        end
        i_out_ready <= take;
    end

    task automatic compare_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        tcgr_pkg::t_result want;
        logic              moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && o_in_ready) begin
                render_request(i_in_data);
                accepted_requests++;
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (expected_draws.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t ns: result expected none, actual op %0h x %0h y %0h",
                                 $time, o_out_data.op, o_out_data.pixel_x,
                                 o_out_data.pixel_y);
                    end
                end else begin
                    want = expected_draws.pop_front();
                    compare_field("op", want.op, o_out_data.op);
                    compare_field("pixel_x", want.pixel_x, o_out_data.pixel_x);
                    compare_field("pixel_y", want.pixel_y, o_out_data.pixel_y);
                    compare_field("lit_mask", want.lit_mask, o_out_data.lit_mask);
                    compare_field("last", want.last, o_out_data.last);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two by two grid with a two-code font, so wraps and scrolls come quickly.
        set_layout(2, 2, 3, 2, 8'h41, 2);
        push_request(tcgr_pkg::CMD_LOAD, tcgr_pkg::CHAR_QUESTION, 5'd0, 8'hFF);
        push_request(tcgr_pkg::CMD_LOAD, tcgr_pkg::CHAR_QUESTION, 5'd1, 8'h81);
        push_request(tcgr_pkg::CMD_LOAD, 8'h41, 5'd0, 8'hAA);
        push_request(tcgr_pkg::CMD_LOAD, 8'h41, 5'd1, 8'h55);
        push_request(tcgr_pkg::CMD_LOAD, 8'h42, 5'd0, 8'h00);
        push_request(tcgr_pkg::CMD_LOAD, 8'h42, 5'd1, 8'hFF);
        push_request(tcgr_pkg::CMD_LOAD, 8'h00, 5'd0, 8'hFF);
        push_request(tcgr_pkg::CMD_LOAD, 8'hFF, 5'd31, 8'h7E);
        push_request(tcgr_pkg::CMD_PUT, 8'h41, 5'd31, 8'hFF);
        push_request(tcgr_pkg::CMD_PUT, 8'h42, 5'd0, 8'h00);
        push_request(tcgr_pkg::CMD_PUT, 8'h41, 5'd31, 8'hFF);
        push_request(tcgr_pkg::CMD_PUT, 8'h43, 5'd0, 8'h00);
        push_request(tcgr_pkg::CMD_PUT, 8'h41, 5'd31, 8'hFF);
        push_request(tcgr_pkg::CMD_PUT, 8'h00, 5'd0, 8'h00);
        push_request(tcgr_pkg::CMD_PUT, 8'hFF, 5'd31, 8'hFF);
        push_request(tcgr_pkg::CMD_PUT, tcgr_pkg::CHAR_RETURN, 5'd0, 8'h00);
        push_request(tcgr_pkg::CMD_PUT, tcgr_pkg::CHAR_NEWLINE, 5'd31, 8'hFF);
        push_request(tcgr_pkg::CMD_PUT, tcgr_pkg::CHAR_RETURN, 5'd31, 8'hFF);
        push_request(tcgr_pkg::CMD_PUT, 8'h42, 5'd0, 8'h00);
        push_request(tcgr_pkg::CMD_PUT, tcgr_pkg::CHAR_NEWLINE, 5'd0, 8'h00);
        push_request(tcgr_pkg::CMD_PUT, 8'h41, 5'd0, 8'h00);
        wait_idle();

        // Largest grid and font; values above range saturate.
        set_layout(32'h300, 200, 15, 63, 0, 511);
        write_register(REG_SPARE_LOW, 32'hFFFF_FFFF);
        write_register(REG_SPARE_HIGH, 32'h0000_0000);
        repeat (20) queue_char(tcgr_pkg::CHAR_NEWLINE);
        queue_random_text(60);
        wait_idle();

        // One-cell screen below the cursor row, and a font that covers nothing.
        set_layout(0, 0, 0, 0, 255, 0);
        send_idle_pct = 77;
        queue_random_text(70);
        wait_idle();

        set_layout(40, 8, 5, 7, 32, 96);
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        hold_armed     = 1'b1;
        queue_random_text(70);
        wait_idle();

        set_layout(7, 3, 8, 16, 48, 300);
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        queue_random_text(70);
        wait_idle();

        set_layout(80, 30, 4, 3, 0, 256);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_text(90);
        wait_idle();

        if (errors == 0 && expected_draws.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
